/* rtl/block_table_first_fit_allocator_macros.svh */
// Assertion macros shared by the allocator checker.
// Depends on nothing; include once per file that asserts.
`ifndef BLOCK_TABLE_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BLOCK_TABLE_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BTFFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define BTFFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/btffa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes of the first-fit block allocator.
// Depends on nothing.
package btffa_pkg;

   localparam int BLOCKS_DEFAULT = 32;
   localparam int ADDR_W         = 64;
   localparam int OP_W           = 2;
   localparam int ST_W           = 2;
   localparam int SLOT_W         = 5;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_NOFIT    = 2'd1;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic              free;
   } entry_type;

endpackage

/* rtl/block_table_first_fit_allocator.sv */
`timescale 1ns / 1ps
// First-fit block allocator over a table of BLOCKS entries; uses btffa_pkg, btffa_ram.
// Add and the unused code: result strobe in the cycle after the accepting edge, busy stays low.
// Allocate and free scan one slot per cycle through the table RAM's registered read port,
// from slot 0 to the first hit or, on a miss, to the last slot; busy stays high for the scan,
// so no new request is taken until the strobe. The receiver cannot stall.
// Synchronous reset clears the valid marks, the sequencer and the strobe; the RAM keeps data.
module block_table_first_fit_allocator
   import btffa_pkg::*;
#(
   parameter int BLOCKS = BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [SLOT_W-1:0] req_entry_index,
   input  logic [ADDR_W-1:0] req_start_address,
   input  logic [ADDR_W-1:0] req_end_address,
   input  logic              req_initially_free,
   input  logic [ADDR_W-1:0] req_request_size,
   input  logic [ADDR_W-1:0] req_release_address,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic [ST_W-1:0]   rsp_status
);

   localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCKS - 1);

   // Sequencer codes.
   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic              state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BLOCKS-1:0] valid_ff, valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [ST_W-1:0]   rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              slot_ok;
   logic [IDX_W-1:0]  add_slot;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         rd_entry;

   // Shared subtractor: length on add, fit test on allocate, match test on free.
   logic [ADDR_W-1:0] op_a, op_b;
   logic [ADDR_W:0]   diff;
   logic              borrow;
   logic              same;
   logic              hit;

   assign accept   = start && !busy;
   assign busy     = (state_ff == S_SCAN);
   assign slot_ok  = (32'(req_entry_index) < BLOCKS);
   assign add_slot = IDX_W'(req_entry_index);

   always_comb begin
      if (state_ff == S_IDLE) begin
         op_a = req_end_address;
         op_b = req_start_address;
      end else if (op_ff == OP_ALLOC) begin
         op_a = rd_entry.length;
         op_b = key_ff;
      end else begin
         op_a = rd_entry.start;
         op_b = key_ff;
      end
   end

   assign diff   = {1'b0, op_a} - {1'b0, op_b};
   assign borrow = diff[ADDR_W];
   assign same   = (diff[ADDR_W-1:0] == '0);

   // Slot idx_ff is on the RAM read data during the scan; an invalid slot never hits.
   assign hit = valid_ff[idx_ff] &&
                ((op_ff == OP_ALLOC) ? (rd_entry.free && !borrow) : same);

   // Read one slot ahead of the one under test; hold at the last slot.
   assign rd_addr = (state_ff == S_IDLE) ? '0 :
                    ((idx_ff == LAST_IDX) ? idx_ff : idx_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_entry;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_operation;
               idx_in = '0;
               key_in = (req_operation == OP_ALLOC) ? req_request_size : req_release_address;
               case (req_operation)
                  OP_ALLOC, OP_FREE: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     // Add or unused code: answer at once.
                     rsp_valid_in  = 1'b1;
                     rsp_addr_in   = '0;
                     rsp_status_in = ST_OK;
                     if (req_operation == OP_ADD && slot_ok) begin
                        wr_en          = 1'b1;
                        wr_addr        = add_slot;
                        wr_data.start  = req_start_address;
                        // Saturate the length to zero when end lies below start.
                        wr_data.length = borrow ? '0 : diff[ADDR_W-1:0];
                        wr_data.free   = req_initially_free;
                        valid_in[add_slot] = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               // Write back the slot with its new free mark.
               wr_en         = 1'b1;
               wr_addr       = idx_ff;
               wr_data       = rd_entry;
               wr_data.free  = (op_ff == OP_FREE);
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = (op_ff == OP_ALLOC) ? rd_entry.start : '0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = (op_ff == OP_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan bookkeeping need no reset.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   btffa_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (BLOCKS),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

/* rtl/btffa_ram.sv */
`timescale 1ns / 1ps
// Generic RAM: one write port, one read port with registered data.
// Depends on nothing.
module btffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/btffa_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the allocator, bound to the top level.
// Depends on btffa_pkg and block_table_first_fit_allocator_macros.svh.
`include "block_table_first_fit_allocator_macros.svh"

module btffa_checker
   import btffa_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [OP_W-1:0]   req_operation,
   input logic              rsp_valid,
   input logic [ADDR_W-1:0] rsp_result_address,
   input logic [ST_W-1:0]   rsp_status
);

   logic acc_add;
   logic acc_scan;
   logic rsp_ok;
   logic rsp_fail;
   logic busy_quiet;
   logic addr_zero;
   logic all_idle;

   assign acc_add    = start && !busy && req_operation == OP_ADD;
   assign acc_scan   = start && !busy && (req_operation == OP_ALLOC || req_operation == OP_FREE);
   assign rsp_ok     = rsp_valid && rsp_status == ST_OK;
   assign rsp_fail   = rsp_valid && rsp_status != ST_OK;
   assign busy_quiet = busy && !rsp_valid;
   assign addr_zero  = (rsp_result_address == '0);
   assign all_idle   = !busy && !rsp_valid;

   // An add answers OK in the next cycle.
   `BTFFA_ASSERT(a_add_answers, clock, reset, acc_add |=> rsp_ok, "add request not answered OK")
   // An allocate or free starts a scan.
   `BTFFA_ASSERT(a_scan_starts, clock, reset, acc_scan |=> busy_quiet, "scan did not raise busy")
   // The end of a scan delivers its result.
   `BTFFA_ASSERT(a_scan_end, clock, reset, $fell(busy) && !$past(reset) |-> rsp_valid, "no result")
   // A failed request returns a zero address.
   `BTFFA_ASSERT(a_fail_zero, clock, reset, rsp_fail |-> addr_zero, "nonzero failure address")
   // Reset drops the sequencer and the strobe.
   `BTFFA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> all_idle, "reset left the block busy")

endmodule

bind block_table_first_fit_allocator btffa_checker u_btffa_checker (.*);
